[design/spq_pkg.sv]
// shared types and codes for the stable sorted priority queue
`default_nettype none

package spq_pkg;

    localparam int PRIO_W  = 8;
    localparam int TAG_W   = 64;
    localparam int STAT_W  = 2;
    localparam int CNTO_W  = 5;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 80;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic              ld;     // apply the command this cycle
        logic              pop;    // 1 shift toward the head, 0 ordered insert
        logic [PRIO_W-1:0] prio;   // priority of the entry being inserted
    } t_cell_ctl;

endpackage

`default_nettype wire

[design/stable_sorted_priority_queue.sv]
// top level of the stable sorted priority queue
`default_nettype none

// Bounded priority queue of DEPTH entries (tag plus 8-bit priority) kept in
// ascending priority order in a chain of cells, head at cell 0; equal
// priorities leave first in, first out. Every cell compares its own priority
// with the incoming one in parallel and either holds, takes the new entry, or
// takes its neighbor's entry, so an insert or a pop completes at the clock
// edge at which the transaction is accepted; the result lands in an output
// register at that same edge and is offered on the master side in the next
// cycle. A new transaction is taken whenever the output register is empty
// or being drained, so the sustained rate is one operation per cycle while
// the master side does not stall; the critical path is one 8-bit compare per
// cell plus the neighbor select. Each operation returns exactly one result:
// status (ok, underflow on pop of an empty queue, insert dropped when full),
// the popped entry when a pop removed one (zeros otherwise) and the entry
// count after the operation (low 5 bits). Only the low TAG_BITS bits of a tag
// are stored. Reset clears only the count and output valid, not the entries.
module stable_sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // slave side
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [0] op, [64:1] tag, [72:65] priority_req, [79:73] zero
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // master side
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [1:0] status, [2] popped_valid, [66:3] popped_tag,
    // [74:67] popped_priority, [79:75] entry_count
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // unpacked input transaction
    logic                w_op;
    logic [TAG_BITS-1:0] w_tag;
    logic [PRIO_W-1:0]   w_prio;
    logic                w_accept;

    assign w_op     = s_axis_tdata[0];
    assign w_tag    = s_axis_tdata[TAG_BITS:1];
    assign w_prio   = s_axis_tdata[1+TAG_W +: PRIO_W];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // occupancy and output register
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic              r_pvalid;
    logic              n_pvalid;
    logic [TAG_W-1:0]  r_ptag;
    logic [PRIO_W-1:0] r_pprio;

    logic w_full;
    logic w_empty;
    t_cell_ctl w_ctl;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // output register frees up when empty or drained this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pvalid = 1'b0;
        w_ctl.ld   = 1'b0;
        w_ctl.pop  = (w_op == OP_POP);
        w_ctl.prio = w_prio;
        if (w_op == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.ld = w_accept;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                w_ctl.ld = w_accept;
                n_pvalid = 1'b1;
                n_count  = r_count - 1'b1;
            end
        end
    end

    // the chain of cells, head at index 0
    logic [TAG_BITS-1:0] w_ctag [DEPTH];
    logic [PRIO_W-1:0]   w_cprio [DEPTH];
    logic                w_ckeep [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                w_pkeep;
        logic [TAG_BITS-1:0] w_ptag;
        logic [PRIO_W-1:0]   w_pprio;
        logic [TAG_BITS-1:0] w_ntag;
        logic [PRIO_W-1:0]   w_nprio;

        if (g == 0) begin : g_head
            // nothing ahead of the head: a new entry lands here unless kept
            assign w_pkeep = 1'b1;
            assign w_ptag  = w_tag;
            assign w_pprio = w_prio;
        end else begin : g_mid
            assign w_pkeep = w_ckeep[g-1];
            assign w_ptag  = w_ctag[g-1];
            assign w_pprio = w_cprio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // tail slot becomes unoccupied on pop, its contents do not matter
            assign w_ntag  = w_ctag[g];
            assign w_nprio = w_cprio[g];
        end else begin : g_body
            assign w_ntag  = w_ctag[g+1];
            assign w_nprio = w_cprio[g+1];
        end

        spq_cell #(
            .IDX      (g),
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_new_tag   (w_tag),
            .i_prev_keep (w_pkeep),
            .i_prev_tag  (w_ptag),
            .i_prev_prio (w_pprio),
            .i_next_tag  (w_ntag),
            .i_next_prio (w_nprio),
            .o_keep      (w_ckeep[g]),
            .o_tag       (w_ctag[g]),
            .o_prio      (w_cprio[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, captured with the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_pvalid <= n_pvalid;
            r_ptag   <= n_pvalid ? TAG_W'(w_ctag[0]) : '0;
            r_pprio  <= n_pvalid ? w_cprio[0] : '0;
        end
    end

    logic [CNT_W-1:0] w_count_ext;
    assign w_count_ext = r_count;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {CNTO_W'(w_count_ext), r_pprio, r_ptag, r_pvalid, r_status};

endmodule

`default_nettype wire

[design/spq_cell.sv]
// one slot of the sorted chain: holds an entry and trades with its neighbors
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int TAG_BITS = 64,
    parameter int CNT_W    = 5
) (
    input  wire logic                i_clk,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [CNT_W-1:0]    i_count,
    input  wire logic [TAG_BITS-1:0] i_new_tag,
    input  wire logic                i_prev_keep,
    input  wire logic [TAG_BITS-1:0] i_prev_tag,
    input  wire logic [PRIO_W-1:0]   i_prev_prio,
    input  wire logic [TAG_BITS-1:0] i_next_tag,
    input  wire logic [PRIO_W-1:0]   i_next_prio,
    output logic                     o_keep,
    output logic [TAG_BITS-1:0]      o_tag,
    output logic [PRIO_W-1:0]        o_prio
);

    logic [TAG_BITS-1:0] r_tag;
    logic [PRIO_W-1:0]   r_prio;
    logic [TAG_BITS-1:0] n_tag;
    logic [PRIO_W-1:0]   n_prio;
    logic                w_occupied;

    assign w_occupied = CNT_W'(IDX) < i_count;
    // entry stays ahead of the new one when its priority is not larger
    assign o_keep     = w_occupied && (r_prio <= i_ctl.prio);

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_ctl.pop) begin
            n_tag  = i_next_tag;
            n_prio = i_next_prio;
        end else if (!o_keep) begin
            if (i_prev_keep) begin
                n_tag  = i_new_tag;
                n_prio = i_ctl.prio;
            end else begin
                n_tag  = i_prev_tag;
                n_prio = i_prev_prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_tag  <= n_tag;
            r_prio <= n_prio;
        end
    end

    assign o_tag  = r_tag;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

[design/spq_chk.sv]
// port-level checker for the stable sorted priority queue, bound to the top
`default_nettype none

module spq_chk
    import spq_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [S_DATA_W-1:0] s_axis_tdata,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no new transaction while a result waits unaccepted
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // every accepted transaction shows a result in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("result missing after transaction");

    // a popped entry only comes with ok status, and status never reads 3
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)
            && (!m_axis_tdata[2] || m_axis_tdata[1:0] == ST_OK))
        else $error("bad status for result");

    // any result without a popped entry reports zero payload
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[74:3] == '0)
        else $error("payload not zero without pop");

endmodule

bind stable_sorted_priority_queue spq_chk u_spq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[bench/spq_result_checker.sv]
`timescale 1ns / 100ps
// scoreboard that mirrors the priority queue and checks every result transaction

module spq_result_checker
    import spq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    // [0] op, [64:1] tag, [72:65] priority_req, [79:73] zero
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    // [1:0] status, [2] popped_valid, [66:3] popped_tag,
    // [74:67] popped_priority, [79:75] entry_count
    input  wire logic [M_DATA_W-1:0] i_m_tdata,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_drops,
    output int                       o_underflows
);

    // same bit layout as the master tdata, lowest field last
    typedef struct packed {
        logic [CNTO_W-1:0] count;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic              popped;
        logic [STAT_W-1:0] status;
    } t_queue_result;

    localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - TAG_BITS);

    logic [TAG_W-1:0]  held_tags [DEPTH];
    logic [PRIO_W-1:0] held_prios[DEPTH];
    int                held_count;
    t_queue_result     awaited_results[$];
    int                error_total, checked_total, drop_total, underflow_total;

    // apply one operation to the mirror and return the result it must produce
    function automatic t_queue_result apply_queue_op(input logic op,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic [PRIO_W-1:0] prio);
        t_queue_result res;
        int            pos;
        int            i;
        res = '0;
        if (op == OP_INSERT) begin
            if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // goes behind every entry of lower or equal priority
                pos = 0;
                while (pos < held_count && held_prios[pos] <= prio)
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_tags[i]  = held_tags[i-1];
                    held_prios[i] = held_prios[i-1];
                end
                held_tags[pos]  = tag & TAG_MASK;
                held_prios[pos] = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = ST_UNDERFLOW;
        end else begin
            res.popped = 1'b1;
            res.tag    = held_tags[0];
            res.prio   = held_prios[0];
            for (i = 1; i < held_count; i++) begin
                held_tags[i-1]  = held_tags[i];
                held_prios[i-1] = held_prios[i];
            end
            held_count--;
        end
        res.count = CNTO_W'(held_count);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [TAG_W-1:0] exp_val,
                                        input logic [TAG_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            error_total++;
        end
    endfunction

    initial begin
        error_total     = 0;
        checked_total   = 0;
        drop_total      = 0;
        underflow_total = 0;
        held_count      = 0;
    end

    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (!i_rst_n) begin
            held_count = 0;
            awaited_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                want = apply_queue_op(i_s_tdata[0], i_s_tdata[TAG_W:1],
                                      i_s_tdata[TAG_W+PRIO_W:TAG_W+1]);
                if (want.status == ST_FULL)
                    drop_total++;
                if (want.status == ST_UNDERFLOW)
                    underflow_total++;
                awaited_results.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_queue_result'(i_m_tdata);
                if (awaited_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, actual %0h",
                             $time, i_m_tdata);
                    error_total++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", TAG_W'(want.status), TAG_W'(got.status));
                    check_field("popped_valid", TAG_W'(want.popped), TAG_W'(got.popped));
                    check_field("popped_tag", want.tag, got.tag);
                    check_field("popped_priority", TAG_W'(want.prio), TAG_W'(got.prio));
                    check_field("entry_count", TAG_W'(want.count), TAG_W'(got.count));
                    checked_total++;
                end
            end
        end
        o_errors     <= error_total;
        o_pending    <= awaited_results.size();
        o_checked    <= checked_total;
        o_drops      <= drop_total;
        o_underflows <= underflow_total;
    end

endmodule

[bench/tb_stable_sorted_priority_queue.sv]
`timescale 1ns / 100ps
// stimulus, clock and verdict for the stable sorted priority queue

module tb_stable_sorted_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_OPS  = 1850;
    localparam int CYCLE_LIMIT = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [0] op, [64:1] tag, [72:65] priority_req, [79:73] zero
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [1:0] status, [2] popped_valid, [66:3] popped_tag,
    // [74:67] popped_priority, [79:75] entry_count
    logic [M_DATA_W-1:0] m_axis_tdata;

    // set while both sides run without any idle cycles
    logic quiet = 1'b0;
    int   cycles = 0;
    int   op_total = 0;
    int   errors, pending, checked, drops, underflows;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stable_sorted_priority_queue #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_W)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    spq_result_checker #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_W)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_drops      (drops),
        .o_underflows (underflows)
    );

    // receiver backpressure, about a third of the cycles outside the quiet stretch
    always @(negedge clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 34);
    end

    // run guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_stable_sorted_priority_queue: done, errors");
            $finish;
        end
    end

    // offer one operation, with random idle cycles ahead of it, and hold it until taken
    task automatic issue_op(input logic op, input logic [TAG_W-1:0] tag,
                            input logic [PRIO_W-1:0] prio);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - TAG_W - PRIO_W - 1){1'b0}}, prio, tag, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        op_total++;
    endtask

    initial begin
        int               issued;
        int               phase_left;
        int               phase_no;
        int               insert_pct;
        int               prio_mode;
        logic             op;
        logic [TAG_W-1:0] tag;
        logic [PRIO_W-1:0] prio;

        issued   = 0;
        phase_no = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pop of an empty queue right after reset
        issue_op(OP_POP, '0, '0);
        // field extremes, equal priorities in arrival order, tie at the back
        issue_op(OP_INSERT, {TAG_W{1'b1}}, 8'hff);
        issue_op(OP_INSERT, '0, 8'h00);
        issue_op(OP_INSERT, 64'h0123_4567_89ab_cdef, 8'h00);
        issue_op(OP_INSERT, 64'h6a6f_6273_6e61_6d65, 8'h80);
        issue_op(OP_INSERT, 64'hfedc_ba98_7654_3210, 8'hff);
        repeat (5) issue_op(OP_POP, {TAG_W{1'b1}}, 8'hff);
        issue_op(OP_POP, '0, '0);

        // phases alternate between filling, draining and mixed traffic, so that
        // full-queue drops and empty pops both come up again and again
        while (issued < RANDOM_OPS) begin
            phase_left = $urandom_range(40, 90);
            case (phase_no % 3)
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            prio_mode = $urandom_range(3);
            phase_no++;
            while (phase_left > 0 && issued < RANDOM_OPS) begin
                quiet = (issued >= 700 && issued < 1000);
                op    = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
                tag   = {$urandom(), $urandom()};
                case (prio_mode)
                    0:       prio = PRIO_W'($urandom_range(3));      // many ties
                    1:       prio = PRIO_W'($urandom_range(255));
                    2:       prio = $urandom_range(1) ? PRIO_W'($urandom_range(1))
                                                      : PRIO_W'($urandom_range(255, 254));
                    default: prio = PRIO_W'($urandom_range(15));
                endcase
                issue_op(op, tag, prio);
                issued++;
                phase_left--;
            end
        end
        quiet = 1'b0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // drain every outstanding result, then let the pipeline settle
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("ran %0d queue operations in %0d phases, %0d results compared",
                 op_total, phase_no, checked);
        $display("including %0d inserts dropped on a full queue and %0d pops of an empty one",
                 drops, underflows);
        if (errors == 0 && pending == 0) begin
            $display("tb_stable_sorted_priority_queue: done, clean");
        end else begin
            $display("tb_stable_sorted_priority_queue: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
design/spq_pkg.sv
design/spq_cell.sv
design/stable_sorted_priority_queue.sv
design/spq_chk.sv
bench/spq_result_checker.sv
bench/tb_stable_sorted_priority_queue.sv
